// ----- rtl/cbt_pkg.sv -----
// ---------------------------------------------------------------------------
// cbt_pkg: shared types and constants of the cubic Bezier tesselator
// Segment limits, vertex kinds, divider lengths and the sequencer states.
// ---------------------------------------------------------------------------
package cbt_pkg;

   // Maximum number of subsegments per path segment.
   localparam int MAX_SEGMENTS = 64;
   // Bits for a segment count or a point index (holds MAX_SEGMENTS itself).
   localparam int SEG_W  = $clog2(MAX_SEGMENTS + 1);
   // Bits for squares and cubes of a segment count.
   localparam int SQ_W   = 2 * SEG_W;
   localparam int CUBE_W = 3 * SEG_W;

   // Minimum subsegment length register.
   localparam int            MSL_W     = 31;
   localparam logic [30:0]   MSL_RESET = 31'd2097152;

   // Vertex kinds.
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_CORNER = 2'd0;
   localparam kind_type KIND_SMOOTH = 2'd1;
   localparam kind_type KIND_AUTO   = 2'd2;
   localparam kind_type KIND_ALT    = 2'd3;

   // Quotient lengths for the divider, one per use.
   typedef logic [6:0] qlen_type;
   localparam qlen_type QLEN_NSEG   = 7'd33;
   localparam qlen_type QLEN_OFFSET = 7'd50;
   localparam qlen_type QLEN_POINT  = 7'd32;
   localparam qlen_type QLEN_WEIGHT = 7'd16;
   localparam qlen_type QLEN_COLOR  = 7'd8;

   // Sequencer states.
   typedef enum logic [5:0] {
      S_IDLE,
      S_CHECK,
      S_LSQ_X,
      S_LSQ_Y,
      S_LROOT_GO,
      S_LROOT_WAIT,
      S_NSEG_GO,
      S_NSEG_WAIT,
      S_CTRL0,
      S_CTRL1,
      S_ANX2,
      S_ANY2,
      S_AROOT_GO,
      S_AROOT_WAIT,
      S_AMUL_X,
      S_ADIV_X_GO,
      S_ADIV_X_WAIT,
      S_AMUL_Y,
      S_ADIV_Y_GO,
      S_ADIV_Y_WAIT,
      S_CUBE_SQ,
      S_CUBE,
      S_KAA,
      S_K0,
      S_K1,
      S_KBB,
      S_K2,
      S_K3,
      S_PMAC,
      S_PDIV_GO,
      S_PDIV_WAIT,
      S_LMAC,
      S_LDIV_GO,
      S_LDIV_WAIT,
      S_EMIT_PT,
      S_EMIT_VTX
   } state_type;

   // Saturate a wide signed sum to 32 bits.
   function automatic logic [31:0] sat32(input logic signed [51:0] v);
      logic [31:0] r;
      if (v > 52'sh0_0000_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -52'sh0_0000_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/cubic_bezier_polyline_tesselator.sv -----
// ---------------------------------------------------------------------------
// cubic_bezier_polyline_tesselator: cubic Bezier path tesselator
// Keeps the previous path vertex, fixes smooth control points, and emits
// the interior points of each cubic segment followed by the vertex itself.
//
//   Channel | Direction | Handshake          | Word
//   req     | in        | req_valid/stall    | one path vertex
//   rsp     | out       | rsp_valid/stall    | one emitted point
//   csr     | in        | csr_wr_en          | min_seg_len
//
// A curved segment first finds its length (root) and subsegment count
// (division), then each autosmooth end, then each interior point in turn;
// all of these share the one multiplier, divider and root unit.
// Reset is synchronous; min_seg_len returns to 32.0, the previous vertex
// is cleared. The block takes one vertex at a time and holds req_stall
// high until the last word of the vertex is taken; rsp_stall freezes it.
// ---------------------------------------------------------------------------
module cubic_bezier_polyline_tesselator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_start_of_path,
   input  logic [1:0]   req_vertex_kind,
   input  logic [31:0]  req_pos_x,
   input  logic [31:0]  req_pos_y,
   input  logic [15:0]  req_weight,
   input  logic [31:0]  req_color_rgba,
   input  logic [31:0]  req_ctrl_in_x,
   input  logic [31:0]  req_ctrl_in_y,
   input  logic [31:0]  req_ctrl_out_x,
   input  logic [31:0]  req_ctrl_out_y,
   input  logic [15:0]  req_normal_x,
   input  logic [15:0]  req_normal_y,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [31:0]  rsp_out_pos_x,
   output logic [31:0]  rsp_out_pos_y,
   output logic [15:0]  rsp_out_weight,
   output logic [31:0]  rsp_out_color,
   output logic         rsp_last_of_run,
   input  logic         csr_wr_en,
   input  logic [30:0]  csr_wr_data
);

   localparam int SEG_W  = cbt_pkg::SEG_W;
   localparam int SQ_W   = cbt_pkg::SQ_W;
   localparam int CUBE_W = cbt_pkg::CUBE_W;

   cbt_pkg::state_type state_ff, state_in;

   logic [30:0]        msl_ff;

   // Previous vertex.
   logic [31:0]        prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [31:0]        prev_cox_ff, prev_cox_in, prev_coy_ff, prev_coy_in;
   logic [15:0]        prev_nx_ff, prev_nx_in, prev_ny_ff, prev_ny_in;
   logic [15:0]        prev_w_ff, prev_w_in;
   logic [31:0]        prev_col_ff, prev_col_in;
   cbt_pkg::kind_type  prev_kind_ff, prev_kind_in;
   logic               prev_valid_ff, prev_valid_in;

   // Current vertex.
   logic               sop_ff, sop_in;
   cbt_pkg::kind_type  kind_ff, kind_in;
   logic [31:0]        pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [15:0]        w_ff, w_in;
   logic [31:0]        col_ff, col_in;
   logic [31:0]        cin_x_ff, cin_x_in, cin_y_ff, cin_y_in;
   logic [31:0]        cout_x_ff, cout_x_in, cout_y_ff, cout_y_in;
   logic [15:0]        nx_ff, nx_in, ny_ff, ny_in;

   // Working registers.
   logic [63:0]        acc_ff, acc_in;
   logic [32:0]        len_ff, len_in;
   logic [SEG_W-1:0]   nseg_ff, nseg_in;
   logic [SEG_W-1:0]   j_ff, j_in;
   logic [31:0]        c0x_ff, c0x_in, c0y_ff, c0y_in;
   logic [31:0]        c1x_ff, c1x_in, c1y_ff, c1y_in;
   logic               ae_ff, ae_in;
   logic [31:0]        dn_ff, dn_in;
   logic [SQ_W-1:0]    tmp_ff, tmp_in;
   logic [CUBE_W-1:0]  cube_ff, cube_in;
   logic [CUBE_W-1:0]  k0_ff, k0_in, k1_ff, k1_in, k2_ff, k2_in, k3_ff, k3_in;
   logic [1:0]         term_ff, term_in;
   logic               coord_ff, coord_in;
   logic [2:0]         ch_ff, ch_in;
   logic [31:0]        out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [15:0]        out_w_ff, out_w_in;
   logic [31:0]        out_c_ff, out_c_in;

   // Shared units.
   logic [32:0]        mul_a, mul_b;
   logic [65:0]        prod;
   logic               div_start, div_done;
   logic [63:0]        div_num, div_quo;
   logic [31:0]        div_den;
   cbt_pkg::qlen_type  div_q;
   logic               sq_start, sq_done;
   logic [63:0]        sq_op;
   logic [31:0]        sq_root;

   // Derived values.
   logic               in_take, out_take;
   logic signed [32:0] dx, dy;
   logic [32:0]        ux, uy;
   logic               big_d;
   logic [31:0]        uxs, uys;
   logic [15:0]        sel_nx, sel_ny;
   logic [31:0]        sel_px, sel_py;
   logic [16:0]        nxe, nye, mag_nx, mag_ny;
   logic               neg_ox, neg_oy;
   logic signed [51:0] ofs_mag, ofs_val, ofs_sum;
   logic [31:0]        ofs_base;
   logic               ofs_neg;
   logic [31:0]        sat_res;
   logic [SEG_W-1:0]   a_coef;
   logic [31:0]        pt_val;
   logic [CUBE_W-1:0]  pt_k;
   logic [15:0]        lerp_a, lerp_b;
   logic [1:0]         cidx;
   logic [32:0]        nseg_q;

   assign in_take  = req_valid && !req_stall;
   assign out_take = rsp_valid && !rsp_stall;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         msl_ff <= cbt_pkg::MSL_RESET;
      end else if (csr_wr_en) begin
         msl_ff <= csr_wr_data;
      end
   end

   // Control and previous-vertex state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cbt_pkg::S_IDLE;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_cox_ff   <= '0;
         prev_coy_ff   <= '0;
         prev_nx_ff    <= '0;
         prev_ny_ff    <= '0;
         prev_w_ff     <= '0;
         prev_col_ff   <= '0;
         prev_kind_ff  <= cbt_pkg::KIND_CORNER;
         prev_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         prev_cox_ff   <= prev_cox_in;
         prev_coy_ff   <= prev_coy_in;
         prev_nx_ff    <= prev_nx_in;
         prev_ny_ff    <= prev_ny_in;
         prev_w_ff     <= prev_w_in;
         prev_col_ff   <= prev_col_in;
         prev_kind_ff  <= prev_kind_in;
         prev_valid_ff <= prev_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      sop_ff   <= sop_in;
      kind_ff  <= kind_in;
      pos_x_ff <= pos_x_in;
      pos_y_ff <= pos_y_in;
      w_ff     <= w_in;
      col_ff   <= col_in;
      cin_x_ff <= cin_x_in;
      cin_y_ff <= cin_y_in;
      cout_x_ff <= cout_x_in;
      cout_y_ff <= cout_y_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      acc_ff   <= acc_in;
      len_ff   <= len_in;
      nseg_ff  <= nseg_in;
      j_ff     <= j_in;
      c0x_ff   <= c0x_in;
      c0y_ff   <= c0y_in;
      c1x_ff   <= c1x_in;
      c1y_ff   <= c1y_in;
      ae_ff    <= ae_in;
      dn_ff    <= dn_in;
      tmp_ff   <= tmp_in;
      cube_ff  <= cube_in;
      k0_ff    <= k0_in;
      k1_ff    <= k1_in;
      k2_ff    <= k2_in;
      k3_ff    <= k3_in;
      term_ff  <= term_in;
      coord_ff <= coord_in;
      ch_ff    <= ch_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_w_ff <= out_w_in;
      out_c_ff <= out_c_in;
   end

   // Segment deltas; both halve when either no longer fits 31 bits.
   always_comb begin
      dx    = {pos_x_ff[31], pos_x_ff} - {prev_x_ff[31], prev_x_ff};
      dy    = {pos_y_ff[31], pos_y_ff} - {prev_y_ff[31], prev_y_ff};
      ux    = dx[32] ? 33'(-dx) : 33'(dx);
      uy    = dy[32] ? 33'(-dy) : 33'(dy);
      big_d = ux[32] | ux[31] | uy[32] | uy[31];
      uxs   = big_d ? ux[32:1] : ux[31:0];
      uys   = big_d ? uy[32:1] : uy[31:0];
   end

   // Autosmooth end selection, normal magnitudes and offset signs.
   always_comb begin
      sel_nx = ae_ff ? nx_ff : prev_nx_ff;
      sel_ny = ae_ff ? ny_ff : prev_ny_ff;
      sel_px = ae_ff ? pos_x_ff : prev_x_ff;
      sel_py = ae_ff ? pos_y_ff : prev_y_ff;
      nxe    = {sel_nx[15], sel_nx};
      nye    = {sel_ny[15], sel_ny};
      mag_nx = nxe[16] ? 17'(-nxe) : nxe;
      mag_ny = nye[16] ? 17'(-nye) : nye;
      // The start end takes the offset negated.
      neg_ox = ae_ff ? (!sel_ny[15] && (sel_ny != '0)) : sel_ny[15];
      neg_oy = ae_ff ? sel_nx[15] : (!sel_nx[15] && (sel_nx != '0));
   end

   // Signed offset added to the end position, saturated.
   always_comb begin
      ofs_neg  = (state_ff == cbt_pkg::S_ADIV_Y_WAIT) ? neg_oy : neg_ox;
      ofs_base = (state_ff == cbt_pkg::S_ADIV_Y_WAIT) ? sel_py : sel_px;
      ofs_mag  = signed'({2'b00, div_quo[49:0]});
      ofs_val  = ofs_neg ? -ofs_mag : ofs_mag;
      ofs_sum  = signed'({{20{ofs_base[31]}}, ofs_base}) + ofs_val;
      sat_res  = cbt_pkg::sat32(ofs_sum);
   end

   // Curve and lerp operands.
   always_comb begin
      a_coef = nseg_ff - j_ff;
      pt_val = '0;
      pt_k   = '0;
      unique case (term_ff)
         2'd0: begin
            pt_val = coord_ff ? prev_y_ff : prev_x_ff;
            pt_k   = k0_ff;
         end
         2'd1: begin
            pt_val = coord_ff ? c0y_ff : c0x_ff;
            pt_k   = k1_ff;
         end
         2'd2: begin
            pt_val = coord_ff ? c1y_ff : c1x_ff;
            pt_k   = k2_ff;
         end
         2'd3: begin
            pt_val = coord_ff ? pos_y_ff : pos_x_ff;
            pt_k   = k3_ff;
         end
         default: begin
            pt_val = '0;
            pt_k   = '0;
         end
      endcase
      cidx   = 2'(ch_ff - 3'd1);
      lerp_a = (ch_ff == 3'd0) ? prev_w_ff : {8'h00, prev_col_ff[8*cidx +: 8]};
      lerp_b = (ch_ff == 3'd0) ? w_ff : {8'h00, col_ff[8*cidx +: 8]};
   end

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         cbt_pkg::S_LSQ_X: begin
            mul_a = 33'(uxs);
            mul_b = 33'(uxs);
         end
         cbt_pkg::S_LSQ_Y: begin
            mul_a = 33'(uys);
            mul_b = 33'(uys);
         end
         cbt_pkg::S_ANX2: begin
            mul_a = 33'(mag_nx);
            mul_b = 33'(mag_nx);
         end
         cbt_pkg::S_ANY2: begin
            mul_a = 33'(mag_ny);
            mul_b = 33'(mag_ny);
         end
         cbt_pkg::S_AMUL_X: begin
            mul_a = 33'(mag_ny);
            mul_b = len_ff;
         end
         cbt_pkg::S_AMUL_Y: begin
            mul_a = 33'(mag_nx);
            mul_b = len_ff;
         end
         cbt_pkg::S_CUBE_SQ: begin
            mul_a = 33'(nseg_ff);
            mul_b = 33'(nseg_ff);
         end
         cbt_pkg::S_CUBE: begin
            mul_a = 33'(tmp_ff);
            mul_b = 33'(nseg_ff);
         end
         cbt_pkg::S_KAA: begin
            mul_a = 33'(a_coef);
            mul_b = 33'(a_coef);
         end
         cbt_pkg::S_K0, cbt_pkg::S_K2: begin
            mul_a = 33'(tmp_ff);
            mul_b = 33'(a_coef);
         end
         cbt_pkg::S_K1, cbt_pkg::S_K3: begin
            mul_a = 33'(tmp_ff);
            mul_b = 33'(j_ff);
         end
         cbt_pkg::S_KBB: begin
            mul_a = 33'(j_ff);
            mul_b = 33'(j_ff);
         end
         cbt_pkg::S_PMAC: begin
            // Positions are biased to unsigned; the quotient's sign bit is flipped back.
            mul_a = 33'(pt_k);
            mul_b = 33'(pt_val ^ 32'h8000_0000);
         end
         cbt_pkg::S_LMAC: begin
            mul_a = (term_ff == 2'd0) ? 33'(lerp_a) : 33'(lerp_b);
            mul_b = (term_ff == 2'd0) ? 33'(a_coef) : 33'(j_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // Shared divider and root operand selection.
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = 32'd1;
      div_q     = cbt_pkg::QLEN_COLOR;
      sq_start  = 1'b0;
      sq_op     = acc_ff;
      unique case (state_ff)
         cbt_pkg::S_LROOT_GO: begin
            sq_start = 1'b1;
         end
         cbt_pkg::S_AROOT_GO: begin
            sq_start = 1'b1;
            sq_op    = {acc_ff[47:0], 16'h0000};
         end
         cbt_pkg::S_NSEG_GO: begin
            div_start = 1'b1;
            div_num   = 64'(len_ff);
            div_den   = (msl_ff == '0) ? 32'd1 : {1'b0, msl_ff};
            div_q     = cbt_pkg::QLEN_NSEG;
         end
         cbt_pkg::S_ADIV_X_GO, cbt_pkg::S_ADIV_Y_GO: begin
            div_start = 1'b1;
            div_num   = acc_ff + 64'(dn_ff >> 1);
            div_den   = dn_ff;
            div_q     = cbt_pkg::QLEN_OFFSET;
         end
         cbt_pkg::S_PDIV_GO: begin
            div_start = 1'b1;
            div_num   = acc_ff + 64'(cube_ff >> 1);
            div_den   = 32'(cube_ff);
            div_q     = cbt_pkg::QLEN_POINT;
         end
         cbt_pkg::S_LDIV_GO: begin
            div_start = 1'b1;
            div_num   = acc_ff + 64'(nseg_ff >> 1);
            div_den   = 32'(nseg_ff);
            div_q     = (ch_ff == 3'd0) ? cbt_pkg::QLEN_WEIGHT : cbt_pkg::QLEN_COLOR;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   cbt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .qlen     (div_q),
      .done     (div_done),
      .quotient (div_quo)
   );

   cbt_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (sq_op),
      .done    (sq_done),
      .root    (sq_root)
   );

   assign nseg_q = div_quo[32:0];

   // Sequencer: next state and register updates.
   always_comb begin
      state_in      = state_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      prev_cox_in   = prev_cox_ff;
      prev_coy_in   = prev_coy_ff;
      prev_nx_in    = prev_nx_ff;
      prev_ny_in    = prev_ny_ff;
      prev_w_in     = prev_w_ff;
      prev_col_in   = prev_col_ff;
      prev_kind_in  = prev_kind_ff;
      prev_valid_in = prev_valid_ff;
      sop_in    = sop_ff;
      kind_in   = kind_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      w_in      = w_ff;
      col_in    = col_ff;
      cin_x_in  = cin_x_ff;
      cin_y_in  = cin_y_ff;
      cout_x_in = cout_x_ff;
      cout_y_in = cout_y_ff;
      nx_in     = nx_ff;
      ny_in     = ny_ff;
      acc_in    = acc_ff;
      len_in    = len_ff;
      nseg_in   = nseg_ff;
      j_in      = j_ff;
      c0x_in    = c0x_ff;
      c0y_in    = c0y_ff;
      c1x_in    = c1x_ff;
      c1y_in    = c1y_ff;
      ae_in     = ae_ff;
      dn_in     = dn_ff;
      tmp_in    = tmp_ff;
      cube_in   = cube_ff;
      k0_in     = k0_ff;
      k1_in     = k1_ff;
      k2_in     = k2_ff;
      k3_in     = k3_ff;
      term_in   = term_ff;
      coord_in  = coord_ff;
      ch_in     = ch_ff;
      out_x_in  = out_x_ff;
      out_y_in  = out_y_ff;
      out_w_in  = out_w_ff;
      out_c_in  = out_c_ff;

      unique case (state_ff)
         cbt_pkg::S_IDLE: begin
            // Take a vertex; the unused kind code acts as a corner.
            if (in_take) begin
               sop_in    = req_start_of_path;
               kind_in   = (req_vertex_kind == cbt_pkg::KIND_ALT) ?
                           cbt_pkg::KIND_CORNER : req_vertex_kind;
               pos_x_in  = req_pos_x;
               pos_y_in  = req_pos_y;
               w_in      = req_weight;
               col_in    = req_color_rgba;
               cin_x_in  = req_ctrl_in_x;
               cin_y_in  = req_ctrl_in_y;
               cout_x_in = req_ctrl_out_x;
               cout_y_in = req_ctrl_out_y;
               nx_in     = req_normal_x;
               ny_in     = req_normal_y;
               state_in  = cbt_pkg::S_CHECK;
            end
         end
         cbt_pkg::S_CHECK: begin
            if (sop_ff || !prev_valid_ff ||
                (prev_kind_ff == cbt_pkg::KIND_CORNER &&
                 kind_ff == cbt_pkg::KIND_CORNER)) begin
               state_in = cbt_pkg::S_EMIT_VTX;
            end else begin
               state_in = cbt_pkg::S_LSQ_X;
            end
         end
         // Segment length: sum of squares, then the root.
         cbt_pkg::S_LSQ_X: begin
            acc_in   = prod[63:0];
            state_in = cbt_pkg::S_LSQ_Y;
         end
         cbt_pkg::S_LSQ_Y: begin
            acc_in   = acc_ff + prod[63:0];
            state_in = cbt_pkg::S_LROOT_GO;
         end
         cbt_pkg::S_LROOT_GO: begin
            state_in = cbt_pkg::S_LROOT_WAIT;
         end
         cbt_pkg::S_LROOT_WAIT: begin
            if (sq_done) begin
               len_in   = big_d ? {sq_root, 1'b0} : {1'b0, sq_root};
               state_in = cbt_pkg::S_NSEG_GO;
            end
         end
         // Subsegment count, saturated.
         cbt_pkg::S_NSEG_GO: begin
            state_in = cbt_pkg::S_NSEG_WAIT;
         end
         cbt_pkg::S_NSEG_WAIT: begin
            if (div_done) begin
               if (nseg_q > 33'(cbt_pkg::MAX_SEGMENTS)) begin
                  nseg_in = SEG_W'(cbt_pkg::MAX_SEGMENTS);
               end else begin
                  nseg_in = nseg_q[SEG_W-1:0];
               end
               if (nseg_q < 33'd2) begin
                  state_in = cbt_pkg::S_EMIT_VTX;
               end else begin
                  state_in = cbt_pkg::S_CTRL0;
               end
            end
         end
         // Start control point.
         cbt_pkg::S_CTRL0: begin
            if (prev_kind_ff == cbt_pkg::KIND_AUTO) begin
               ae_in    = 1'b0;
               state_in = cbt_pkg::S_ANX2;
            end else begin
               if (prev_kind_ff == cbt_pkg::KIND_SMOOTH) begin
                  c0x_in = prev_cox_ff;
                  c0y_in = prev_coy_ff;
               end else begin
                  c0x_in = prev_x_ff;
                  c0y_in = prev_y_ff;
               end
               state_in = cbt_pkg::S_CTRL1;
            end
         end
         // End control point.
         cbt_pkg::S_CTRL1: begin
            if (kind_ff == cbt_pkg::KIND_AUTO) begin
               ae_in    = 1'b1;
               state_in = cbt_pkg::S_ANX2;
            end else begin
               if (kind_ff == cbt_pkg::KIND_SMOOTH) begin
                  c1x_in = cin_x_ff;
                  c1y_in = cin_y_ff;
               end else begin
                  c1x_in = pos_x_ff;
                  c1y_in = pos_y_ff;
               end
               state_in = cbt_pkg::S_CUBE_SQ;
            end
         end
         // Autosmooth: normal length with 8 extra fraction bits.
         cbt_pkg::S_ANX2: begin
            acc_in   = prod[63:0];
            state_in = cbt_pkg::S_ANY2;
         end
         cbt_pkg::S_ANY2: begin
            acc_in   = acc_ff + prod[63:0];
            state_in = cbt_pkg::S_AROOT_GO;
         end
         cbt_pkg::S_AROOT_GO: begin
            state_in = cbt_pkg::S_AROOT_WAIT;
         end
         cbt_pkg::S_AROOT_WAIT: begin
            if (sq_done) begin
               if (sq_root == '0) begin
                  // A zero normal leaves the control point on the vertex.
                  if (ae_ff) begin
                     c1x_in   = pos_x_ff;
                     c1y_in   = pos_y_ff;
                     state_in = cbt_pkg::S_CUBE_SQ;
                  end else begin
                     c0x_in   = prev_x_ff;
                     c0y_in   = prev_y_ff;
                     state_in = cbt_pkg::S_CTRL1;
                  end
               end else begin
                  dn_in    = {sq_root[30:0], 1'b0} + sq_root;
                  state_in = cbt_pkg::S_AMUL_X;
               end
            end
         end
         cbt_pkg::S_AMUL_X: begin
            acc_in   = {prod[55:0], 8'h00};
            state_in = cbt_pkg::S_ADIV_X_GO;
         end
         cbt_pkg::S_ADIV_X_GO: begin
            state_in = cbt_pkg::S_ADIV_X_WAIT;
         end
         cbt_pkg::S_ADIV_X_WAIT: begin
            if (div_done) begin
               if (ae_ff) begin
                  c1x_in = sat_res;
               end else begin
                  c0x_in = sat_res;
               end
               state_in = cbt_pkg::S_AMUL_Y;
            end
         end
         cbt_pkg::S_AMUL_Y: begin
            acc_in   = {prod[55:0], 8'h00};
            state_in = cbt_pkg::S_ADIV_Y_GO;
         end
         cbt_pkg::S_ADIV_Y_GO: begin
            state_in = cbt_pkg::S_ADIV_Y_WAIT;
         end
         cbt_pkg::S_ADIV_Y_WAIT: begin
            if (div_done) begin
               if (ae_ff) begin
                  c1y_in   = sat_res;
                  state_in = cbt_pkg::S_CUBE_SQ;
               end else begin
                  c0y_in   = sat_res;
                  state_in = cbt_pkg::S_CTRL1;
               end
            end
         end
         // Common denominator n cubed; first point index.
         cbt_pkg::S_CUBE_SQ: begin
            tmp_in   = prod[SQ_W-1:0];
            state_in = cbt_pkg::S_CUBE;
         end
         cbt_pkg::S_CUBE: begin
            cube_in  = prod[CUBE_W-1:0];
            j_in     = SEG_W'(1);
            state_in = cbt_pkg::S_KAA;
         end
         // Bernstein weights for this point.
         cbt_pkg::S_KAA: begin
            tmp_in   = prod[SQ_W-1:0];
            state_in = cbt_pkg::S_K0;
         end
         cbt_pkg::S_K0: begin
            k0_in    = prod[CUBE_W-1:0];
            state_in = cbt_pkg::S_K1;
         end
         cbt_pkg::S_K1: begin
            k1_in    = prod[CUBE_W-1:0] + {prod[CUBE_W-2:0], 1'b0};
            state_in = cbt_pkg::S_KBB;
         end
         cbt_pkg::S_KBB: begin
            tmp_in   = prod[SQ_W-1:0];
            state_in = cbt_pkg::S_K2;
         end
         cbt_pkg::S_K2: begin
            k2_in    = prod[CUBE_W-1:0] + {prod[CUBE_W-2:0], 1'b0};
            state_in = cbt_pkg::S_K3;
         end
         cbt_pkg::S_K3: begin
            k3_in    = prod[CUBE_W-1:0];
            term_in  = 2'd0;
            coord_in = 1'b0;
            state_in = cbt_pkg::S_PMAC;
         end
         // Weighted sum of the four control values for one coordinate.
         cbt_pkg::S_PMAC: begin
            acc_in  = (term_ff == 2'd0) ? prod[63:0] : acc_ff + prod[63:0];
            term_in = term_ff + 2'd1;
            if (term_ff == 2'd3) begin
               state_in = cbt_pkg::S_PDIV_GO;
            end
         end
         cbt_pkg::S_PDIV_GO: begin
            state_in = cbt_pkg::S_PDIV_WAIT;
         end
         cbt_pkg::S_PDIV_WAIT: begin
            if (div_done) begin
               term_in = 2'd0;
               if (coord_ff) begin
                  out_y_in = div_quo[31:0] ^ 32'h8000_0000;
                  ch_in    = 3'd0;
                  state_in = cbt_pkg::S_LMAC;
               end else begin
                  out_x_in = div_quo[31:0] ^ 32'h8000_0000;
                  coord_in = 1'b1;
                  state_in = cbt_pkg::S_PMAC;
               end
            end
         end
         // Weight, then the four color channels.
         cbt_pkg::S_LMAC: begin
            if (term_ff == 2'd0) begin
               acc_in  = prod[63:0];
               term_in = 2'd1;
            end else begin
               acc_in   = acc_ff + prod[63:0];
               state_in = cbt_pkg::S_LDIV_GO;
            end
         end
         cbt_pkg::S_LDIV_GO: begin
            state_in = cbt_pkg::S_LDIV_WAIT;
         end
         cbt_pkg::S_LDIV_WAIT: begin
            if (div_done) begin
               if (ch_ff == 3'd0) begin
                  out_w_in = div_quo[15:0];
               end else begin
                  out_c_in[8*cidx +: 8] = div_quo[7:0];
               end
               term_in = 2'd0;
               if (ch_ff == 3'd4) begin
                  state_in = cbt_pkg::S_EMIT_PT;
               end else begin
                  ch_in    = ch_ff + 3'd1;
                  state_in = cbt_pkg::S_LMAC;
               end
            end
         end
         cbt_pkg::S_EMIT_PT: begin
            if (out_take) begin
               if (j_ff + SEG_W'(1) == nseg_ff) begin
                  state_in = cbt_pkg::S_EMIT_VTX;
               end else begin
                  j_in     = j_ff + SEG_W'(1);
                  state_in = cbt_pkg::S_KAA;
               end
            end
         end
         // The vertex word ends the run and becomes the previous vertex.
         cbt_pkg::S_EMIT_VTX: begin
            if (out_take) begin
               prev_x_in     = pos_x_ff;
               prev_y_in     = pos_y_ff;
               prev_cox_in   = cout_x_ff;
               prev_coy_in   = cout_y_ff;
               prev_nx_in    = nx_ff;
               prev_ny_in    = ny_ff;
               prev_w_in     = w_ff;
               prev_col_in   = col_ff;
               prev_kind_in  = kind_ff;
               prev_valid_in = 1'b1;
               state_in      = cbt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cbt_pkg::S_IDLE;
         end
      endcase
   end

   // Ports.
   assign req_stall       = (state_ff != cbt_pkg::S_IDLE);
   assign rsp_valid       = (state_ff == cbt_pkg::S_EMIT_PT) ||
                            (state_ff == cbt_pkg::S_EMIT_VTX);
   assign rsp_last_of_run = (state_ff == cbt_pkg::S_EMIT_VTX);
   assign rsp_out_pos_x   = rsp_last_of_run ? pos_x_ff : out_x_ff;
   assign rsp_out_pos_y   = rsp_last_of_run ? pos_y_ff : out_y_ff;
   assign rsp_out_weight  = rsp_last_of_run ? w_ff : out_w_ff;
   assign rsp_out_color   = rsp_last_of_run ? col_ff : out_c_ff;

   // No word is offered while the block is ready for a vertex.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("output word offered while idle");

   // Taking a vertex makes the block busy.
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      in_take |=> req_stall)
      else $error("vertex taken without going busy");

   // Delivering the vertex word frees the block.
   a_vtx_frees: assert property (@(posedge clock) disable iff (reset)
      (out_take && rsp_last_of_run) |=> !req_stall)
      else $error("block stays busy after the vertex word");

   // Interior points lie strictly inside the segment.
   a_pt_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbt_pkg::S_EMIT_PT) |-> (j_ff != '0 && j_ff < nseg_ff))
      else $error("point index out of range");

endmodule

// ----- rtl/cbt_div.sv -----
// ---------------------------------------------------------------------------
// cbt_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, with a quotient length
// chosen per call so that short divisions finish early.
// ---------------------------------------------------------------------------
module cbt_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [63:0]          dividend,
   input  logic [31:0]          divisor,
   input  cbt_pkg::qlen_type    qlen,
   output logic                 done,
   output logic [63:0]          quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [32:0]       rem_ff, rem_in;
   logic [63:0]       num_ff, num_in;
   logic [63:0]       quo_ff, quo_in;
   logic [31:0]       den_ff, den_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic [32:0]       trial;
   logic              ge;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   // One trial subtraction per cycle.
   always_comb begin
      trial   = {rem_ff[31:0], num_ff[63]};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         rem_in  = 33'(dividend >> qlen);
         num_in  = dividend << (7'd64 - qlen);
         quo_in  = '0;
         den_in  = divisor;
         cnt_in  = qlen;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? (trial - {1'b0, den_ff}) : trial;
         num_in = {num_ff[62:0], 1'b0};
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // A new division is only started once the previous one is finished.
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

endmodule

// ----- rtl/cbt_sqrt.sv -----
// ---------------------------------------------------------------------------
// cbt_sqrt: iterative integer square root
// Digit-by-digit root of a 64-bit operand, one result bit per cycle;
// the root is truncated.
// ---------------------------------------------------------------------------
module cbt_sqrt (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  operand,
   output logic         done,
   output logic [31:0]  root
);

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [63:0]  rem_ff, rem_in;
   logic [63:0]  res_ff, res_in;
   logic [63:0]  bit_ff, bit_in;
   logic [63:0]  trial;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   // One root bit per cycle.
   always_comb begin
      trial   = res_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         rem_in  = operand;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

   // A new root is only started once the previous one is finished.
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("square root restarted while busy");

endmodule

// ----- bench/tb_cubic_bezier_polyline_tesselator.sv -----
// ---------------------------------------------------------------------------
// tb_cubic_bezier_polyline_tesselator: self-checking bench for the tesselator
// Sends path vertices, predicts every emitted point of each cubic segment
// and the copied vertex, and checks each rsp word in order, field by field.
// ---------------------------------------------------------------------------
module tb_cubic_bezier_polyline_tesselator;

   timeunit 1ns;
   timeprecision 1ps;

   // One path vertex as it enters the block.
   typedef struct {
      bit                  sop;
      cbt_pkg::kind_type   kind;
      logic [31:0]         px, py;
      logic [15:0]         wgt;
      logic [31:0]         col;
      logic [31:0]         cix, ciy, cox, coy;
      logic [15:0]         nx, ny;
   } vertex_type;

   // One emitted point.
   typedef struct {
      logic [31:0] px, py;
      logic [15:0] wgt;
      logic [31:0] col;
      logic        last;
   } point_type;

   // Tracks the path state and the points still owed by the block.
   class bezier_tracker;
      longint              msl;
      longint              p_pos[2];
      longint              p_cout[2];
      longint              p_nrm[2];
      longint              p_wgt;
      longint              p_col;
      cbt_pkg::kind_type   p_kind;
      bit                  p_valid;
      point_type           owed[$];
      int                  errors;

      function new();
         msl = cbt_pkg::MSL_RESET;
         p_pos = '{0, 0};
         p_cout = '{0, 0};
         p_nrm = '{0, 0};
         p_wgt = 0;
         p_col = 0;
         p_kind = cbt_pkg::KIND_CORNER;
         p_valid = 0;
         errors = 0;
      endfunction

      function longint root_floor(longint n);
         longint r, b;
         r = 0;
         b = 64'sd1 <<< 62;
         while (b > n) b = b >>> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >>> 1) + b;
            end else begin
               r = r >>> 1;
            end
            b = b >>> 2;
         end
         return r;
      endfunction

      function longint magn(longint v);
         return (v < 0) ? -v : v;
      endfunction

      function longint clip32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // Segment length; halves both deltas when one reaches 2^31.
      function longint seg_len(longint x0, longint y0, longint x1, longint y1);
         longint ux, uy;
         int     s;
         ux = magn(x1 - x0);
         uy = magn(y1 - y0);
         s = 0;
         if (ux >= 64'sd2147483648 || uy >= 64'sd2147483648) begin
            ux = ux >>> 1;
            uy = uy >>> 1;
            s = 1;
         end
         return root_floor(ux * ux + uy * uy) <<< s;
      endfunction

      // Offset along one axis, magnitude rounded half away from zero.
      function longint offs(longint comp, longint len, longint n256);
         longint d, q;
         d = 3 * n256;
         q = (magn(comp) * len * 256 + d / 2) / d;
         return (comp < 0) ? -q : q;
      endfunction

      // Autosmooth control point: position +/- unit(-ny, nx) * len / 3.
      function void auto_point(output longint cx, output longint cy,
                               input longint px, input longint py,
                               input longint nx, input longint ny,
                               input longint len, input bit neg);
         longint n256, ox, oy;
         n256 = root_floor((nx * nx + ny * ny) <<< 16);
         if (n256 == 0) begin
            cx = px;
            cy = py;
            return;
         end
         ox = offs(-ny, len, n256);
         oy = offs(nx, len, n256);
         if (neg) begin
            ox = -ox;
            oy = -oy;
         end
         cx = clip32(px + ox);
         cy = clip32(py + oy);
      endfunction

      function longint blend(longint a, longint b, longint n, longint j);
         return (a * (n - j) + b * j + n / 2) / n;
      endfunction

      // Note an accepted vertex and queue the points it must produce.
      function void take_vertex(vertex_type v);
         cbt_pkg::kind_type k;
         longint   pos[2], cin[2], nrm[2], c0[2], c1[2];
         longint   len, seg, n, a, b, d, s, q;
         longint   kk[4];
         point_type pt;
         k = (v.kind == cbt_pkg::KIND_ALT) ? cbt_pkg::KIND_CORNER : v.kind;
         pos[0] = longint'(signed'(v.px));
         pos[1] = longint'(signed'(v.py));
         cin[0] = longint'(signed'(v.cix));
         cin[1] = longint'(signed'(v.ciy));
         nrm[0] = longint'(signed'(v.nx));
         nrm[1] = longint'(signed'(v.ny));
         if (!v.sop && p_valid &&
             (p_kind != cbt_pkg::KIND_CORNER || k != cbt_pkg::KIND_CORNER)) begin
            len = seg_len(p_pos[0], p_pos[1], pos[0], pos[1]);
            seg = len / ((msl == 0) ? 1 : msl);
            if (p_kind == cbt_pkg::KIND_AUTO)
               auto_point(c0[0], c0[1], p_pos[0], p_pos[1], p_nrm[0], p_nrm[1], len, 1);
            else if (p_kind == cbt_pkg::KIND_CORNER)
               c0 = p_pos;
            else
               c0 = p_cout;
            if (k == cbt_pkg::KIND_AUTO)
               auto_point(c1[0], c1[1], pos[0], pos[1], nrm[0], nrm[1], len, 0);
            else if (k == cbt_pkg::KIND_CORNER)
               c1 = pos;
            else
               c1 = cin;
            n = (seg > cbt_pkg::MAX_SEGMENTS) ? cbt_pkg::MAX_SEGMENTS : seg;
            for (longint j = 1; j < n; j++) begin
               a = n - j;
               b = j;
               d = n * n * n;
               kk[0] = a * a * a;
               kk[1] = 3 * a * a * b;
               kk[2] = 3 * a * b * b;
               kk[3] = b * b * b;
               for (int ax = 0; ax < 2; ax++) begin
                  s = kk[0] * p_pos[ax] + kk[1] * c0[ax] + kk[2] * c1[ax]
                      + kk[3] * pos[ax] + d / 2;
                  q = s / d;
                  if (s % d != 0 && s < 0) q--;
                  if (ax == 0) pt.px = q[31:0];
                  else pt.py = q[31:0];
               end
               for (int ch = 0; ch < 4; ch++)
                  pt.col[ch*8 +: 8] = 8'(blend((p_col >> (ch * 8)) & 255,
                                               longint'(v.col[ch*8 +: 8]), n, j));
               pt.wgt = 16'(blend(p_wgt, longint'(v.wgt), n, j));
               pt.last = 0;
               owed.push_back(pt);
            end
         end
         pt.px = v.px;
         pt.py = v.py;
         pt.wgt = v.wgt;
         pt.col = v.col;
         pt.last = 1;
         owed.push_back(pt);
         p_pos = pos;
         p_cout[0] = longint'(signed'(v.cox));
         p_cout[1] = longint'(signed'(v.coy));
         p_nrm = nrm;
         p_wgt = v.wgt;
         p_col = v.col;
         p_kind = k;
         p_valid = 1;
      endfunction

      // Compare one emitted word with the oldest owed point.
      function void check_point(point_type got);
         point_type e;
         if (owed.size() == 0) begin
            $error("unexpected point x=%h y=%h", got.px, got.py);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (got.px !== e.px) begin
            $error("out_pos_x expected %h got %h", e.px, got.px); errors++;
         end
         if (got.py !== e.py) begin
            $error("out_pos_y expected %h got %h", e.py, got.py); errors++;
         end
         if (got.wgt !== e.wgt) begin
            $error("out_weight expected %h got %h", e.wgt, got.wgt); errors++;
         end
         if (got.col !== e.col) begin
            $error("out_color expected %h got %h", e.col, got.col); errors++;
         end
         if (got.last !== e.last) begin
            $error("last_of_run expected %b got %b", e.last, got.last); errors++;
         end
      endfunction
   endclass

   logic         clock, reset;
   logic         req_valid, req_stall, req_start_of_path;
   logic [1:0]   req_vertex_kind;
   logic [31:0]  req_pos_x, req_pos_y, req_color_rgba;
   logic [15:0]  req_weight, req_normal_x, req_normal_y;
   logic [31:0]  req_ctrl_in_x, req_ctrl_in_y, req_ctrl_out_x, req_ctrl_out_y;
   logic         rsp_valid, rsp_stall, rsp_last_of_run;
   logic [31:0]  rsp_out_pos_x, rsp_out_pos_y, rsp_out_color;
   logic [15:0]  rsp_out_weight;
   logic         csr_wr_en;
   logic [30:0]  csr_wr_data;

   bezier_tracker tracker = new();
   int            send_idle, recv_idle, hold_left, quiet;
   longint        last_x, last_y;

   cubic_bezier_polyline_tesselator u_top (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Receiver: check accepted words, then choose the next stall.
   always @(posedge clock) begin
      point_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.px = rsp_out_pos_x;
         got.py = rsp_out_pos_y;
         got.wgt = rsp_out_weight;
         got.col = rsp_out_color;
         got.last = rsp_last_of_run;
         tracker.check_point(got);
      end
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // Watchdog on cycles without any accepted word.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet > 40000) begin
         $display("tb_cubic_bezier_polyline_tesselator: done, errors");
         $finish;
      end
   end

   // Offer one vertex, with random idle cycles first.
   task automatic send_vertex(input vertex_type v);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_start_of_path <= v.sop;
      req_vertex_kind <= v.kind;
      req_pos_x <= v.px;
      req_pos_y <= v.py;
      req_weight <= v.wgt;
      req_color_rgba <= v.col;
      req_ctrl_in_x <= v.cix;
      req_ctrl_in_y <= v.ciy;
      req_ctrl_out_x <= v.cox;
      req_ctrl_out_y <= v.coy;
      req_normal_x <= v.nx;
      req_normal_y <= v.ny;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_vertex(v);
      last_x = longint'(signed'(v.px));
      last_y = longint'(signed'(v.py));
   endtask

   // Drop valid and wait until every owed point has come out.
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (tracker.owed.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_msl(input logic [30:0] val);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      tracker.msl = val;
   endtask

   // Random vertex, mostly a few minimum lengths from the last one.
   function automatic vertex_type rand_vertex();
      vertex_type v;
      longint  step, dx, dy;
      step = (tracker.msl == 0) ? 1 : tracker.msl;
      v.sop = ($urandom_range(99) < 8);
      v.kind = ($urandom_range(99) < 80) ? cbt_pkg::kind_type'($urandom_range(1, 2))
                                          : cbt_pkg::kind_type'($urandom_range(0, 3));
      if ($urandom_range(99) < 5) begin
         v.px = $urandom;
         v.py = $urandom;
      end else begin
         dx = longint'($urandom_range(0, 5)) * step + $urandom_range(0, 65535);
         dy = longint'($urandom_range(0, 2)) * step + $urandom_range(0, 65535);
         if ($urandom_range(1)) dx = -dx;
         if ($urandom_range(1)) dy = -dy;
         v.px = 32'(tracker.clip32(last_x + dx));
         v.py = 32'(tracker.clip32(last_y + dy));
      end
      v.wgt = 16'($urandom);
      v.col = $urandom;
      v.cix = $urandom;
      v.ciy = $urandom;
      v.cox = $urandom;
      v.coy = $urandom;
      v.nx = 16'($urandom);
      v.ny = 16'($urandom);
      return v;
   endfunction

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_vertex(rand_vertex());
   endtask

   // Directed vertex built from a random base.
   task automatic send_set(input bit sop, input cbt_pkg::kind_type k, input longint x,
                           input longint y, input logic [15:0] nx,
                           input logic [15:0] ny);
      vertex_type v;
      v = rand_vertex();
      v.sop = sop;
      v.kind = k;
      v.px = x[31:0];
      v.py = y[31:0];
      v.nx = nx;
      v.ny = ny;
      send_vertex(v);
   endtask

   // Main sequence.
   initial begin
      reset = 1;
      req_valid = 0;
      req_start_of_path = 0;
      req_vertex_kind = cbt_pkg::KIND_CORNER;
      req_pos_x = 0; req_pos_y = 0;
      req_weight = 0; req_color_rgba = 0;
      req_ctrl_in_x = 0; req_ctrl_in_y = 0;
      req_ctrl_out_x = 0; req_ctrl_out_y = 0;
      req_normal_x = 0; req_normal_y = 0;
      rsp_stall = 0;
      csr_wr_en = 0;
      csr_wr_data = 0;
      send_idle = 36;
      recv_idle = 46;
      hold_left = 0;
      quiet = 0;
      last_x = 0;
      last_y = 0;
      repeat (7) @(posedge clock);
      reset <= 0;

      // Directed part at the reset length of 32.0.
      send_set(0, cbt_pkg::KIND_SMOOTH, 64'sd300000, 0, 16'h4000, 0);
      send_set(0, cbt_pkg::KIND_CORNER, 64'sd500000, 64'sd100000, 0, 16'h4000);
      send_set(0, cbt_pkg::KIND_SMOOTH, 64'sd900000, 64'sd100000, 16'h7FFF, 16'h8000);
      send_set(0, cbt_pkg::KIND_AUTO, 64'sd1500000, -64'sd200000, 16'h8000, 16'h7FFF);
      send_set(0, cbt_pkg::KIND_AUTO, 64'sd2000000, -64'sd600000, 0, 0);
      send_set(0, cbt_pkg::KIND_ALT, 64'sd2400000, -64'sd600000, 16'hFFFF, 16'h0001);
      send_set(0, cbt_pkg::KIND_CORNER, 64'sd2800000, -64'sd500000, 0, 0);
      send_set(0, cbt_pkg::KIND_AUTO, 64'sd2810000, -64'sd500000, 16'h2000, 16'h2000);
      send_set(1, cbt_pkg::KIND_AUTO, 64'sd2147483647, 64'sd2147483647,
               16'h7FFF, 16'h7FFF);
      send_set(0, cbt_pkg::KIND_AUTO, -64'sd2147483648, -64'sd2147483648,
               16'h8000, 16'h8000);
      send_set(0, cbt_pkg::KIND_SMOOTH, 64'sd2147483647, -64'sd2147483648,
               16'h0000, 16'h8000);
      send_set(0, cbt_pkg::KIND_SMOOTH, 64'sd2147483647, -64'sd2147480000, 0, 0);
      send_set(1, cbt_pkg::KIND_CORNER, 0, 0, 0, 0);
      send_set(0, cbt_pkg::KIND_CORNER, 64'sd400000, 0, 0, 0);
      send_set(0, cbt_pkg::KIND_SMOOTH, 64'sd400000, 64'sd400000, 16'h4000, 16'hC000);
      send_random(70);

      // Length 1.0: long receiver hold-off while vertices keep coming.
      write_msl(31'd65536);
      send_idle = 46;
      recv_idle = 36;
      hold_left = 3000;
      send_random(40);
      drain();
      send_random(40);

      // No idling: smallest, zero and largest lengths, then 3000000.
      write_msl(31'd1);
      send_idle = 0;
      recv_idle = 0;
      send_set(0, cbt_pkg::KIND_SMOOTH, last_x + 64'sd70000, last_y, 0, 0);
      send_random(6);
      write_msl(31'd0);
      send_random(6);
      write_msl(31'h7FFF_FFFF);
      send_random(30);
      write_msl(31'd3000000);
      send_random(40);

      drain();
      repeat (50) @(posedge clock);
      if (tracker.errors == 0 && tracker.owed.size() == 0)
         $display("tb_cubic_bezier_polyline_tesselator: done, clean");
      else
         $display("tb_cubic_bezier_polyline_tesselator: done, errors");
      $finish;
   end

endmodule
